// ===== rtl/lsf_pkg.sv =====
`timescale 1ns / 1ps

package lsf_pkg;

  // line and pattern limits
  localparam int MAX_LINE_BYTES    = 1024;
  localparam int MAX_PATTERN_BYTES = 16;
  localparam int LEN_W             = $clog2(MAX_LINE_BYTES + 1);
  localparam int PLEN_W            = 5;
  localparam int NSEL_W            = $clog2(MAX_PATTERN_BYTES + 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_SELECT  = 3'd4;

  // input opcodes and special bytes
  localparam logic       OP_DATA      = 1'b0;
  localparam logic       OP_END       = 1'b1;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] UPPER_A      = 8'h41;
  localparam logic [7:0] UPPER_Z      = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // stream widths
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 80;
  localparam int M_TUSER_W = 2;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_NEWLINE,
    KIND_EOS
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [PLEN_W-1:0]              pattern_length;
    logic [MAX_PATTERN_BYTES*8-1:0] pattern;
    logic                           ignore_case;
    logic                           invert_select;
  } cfg_t;

  // fold ascii uppercase to lowercase when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && c >= UPPER_A && c <= UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

endpackage

// ===== rtl/lsf_front.sv =====
`timescale 1ns / 1ps

module lsf_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lsf_pkg::S_TDATA_W-1:0]       s_tdata,
  input  logic                                s_tuser,
  input  logic                                cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_full,
  output logic                                push,
  output lsf_pkg::item_t                      push_item,
  output lsf_pkg::cfg_t                       cfg
);

  // take a request whenever the queue has room
  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  // classify the request
  always_comb begin
    push_item.data_byte = s_tdata[7:0];
    if (s_tuser == lsf_pkg::OP_END) begin
      push_item.kind = lsf_pkg::KIND_EOS;
    end else if (s_tdata[7:0] == lsf_pkg::NEWLINE_BYTE) begin
      push_item.kind = lsf_pkg::KIND_NEWLINE;
    end else begin
      push_item.kind = lsf_pkg::KIND_BYTE;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsf_pkg::REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[lsf_pkg::PLEN_W-1:0];
        lsf_pkg::REG_PATTERN_LOW:    cfg.pattern[63:0] <= cfg_data;
        lsf_pkg::REG_PATTERN_HIGH:   cfg.pattern[127:64] <= cfg_data;
        lsf_pkg::REG_IGNORE_CASE:    cfg.ignore_case <= cfg_data[0];
        lsf_pkg::REG_INVERT_SELECT:  cfg.invert_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lsf_queue.sv =====
`timescale 1ns / 1ps

module lsf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lsf_pkg::item_t  push_item,
  input  logic            pop,
  output logic            q_valid,
  output logic            q_full,
  output lsf_pkg::item_t  q_item
);

  lsf_pkg::item_t                 slots [lsf_pkg::QUEUE_DEPTH];
  logic [lsf_pkg::QPTR_W-1:0]     wr_ptr;
  logic [lsf_pkg::QPTR_W-1:0]     rd_ptr;
  logic [lsf_pkg::QCNT_W-1:0]     count;

  assign q_valid = (count != '0);
  assign q_full  = (count == lsf_pkg::QCNT_W'(lsf_pkg::QUEUE_DEPTH));
  assign q_item  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/lsf_back.sv =====
`timescale 1ns / 1ps

module lsf_back (
  input  logic                             clk,
  input  logic                             rst,
  input  lsf_pkg::cfg_t                    cfg,
  input  logic                             q_valid,
  input  lsf_pkg::item_t                   q_item,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lsf_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [lsf_pkg::M_TUSER_W-1:0]    m_tuser
);

  localparam int NP = lsf_pkg::MAX_PATTERN_BYTES;

  logic [7:0]                 window      [NP];
  logic [7:0]                 window_next [NP];
  logic [7:0]                 fw          [NP];
  logic [7:0]                 fp          [NP];
  logic [lsf_pkg::LEN_W-1:0]  kept_length;
  logic [lsf_pkg::LEN_W-1:0]  kept_inc;
  logic                       found_in_line;
  logic [31:0]                line_counter;
  logic [31:0]                select_counter;
  logic [31:0]                line_inc;
  logic [31:0]                select_inc;
  logic [NP:0]                hit_by_len;
  logic [lsf_pkg::NSEL_W-1:0] used_len;
  logic                       byte_room;
  logic                       hit;
  logic                       matched;
  logic                       produces;

  // result register
  logic                       out_end;
  logic                       out_line;
  logic                       out_selected;
  logic [31:0]                out_number;
  logic [lsf_pkg::LEN_W-1:0]  out_length;
  logic [31:0]                out_count;

  // take from the queue unless a result is blocked
  assign produces = (q_item.kind != lsf_pkg::KIND_BYTE);
  assign pop      = q_valid && (!produces || !m_tvalid || m_tready);

  // shifted window with the new byte in front
  always_comb begin
    window_next[0] = q_item.data_byte;
    for (int i = 1; i < NP; i++) window_next[i] = window[i-1];
    for (int i = 0; i < NP; i++) begin
      fw[i] = lsf_pkg::fold_byte(window_next[i], cfg.ignore_case);
      fp[i] = lsf_pkg::fold_byte(cfg.pattern[i*8 +: 8], cfg.ignore_case);
    end
  end

  // parallel compare for every pattern length
  always_comb begin
    hit_by_len[0] = 1'b0;
    for (int k = 1; k <= NP; k++) begin
      hit_by_len[k] = 1'b1;
      for (int j = 0; j < k; j++) begin
        if (fw[k-1-j] != fp[j]) hit_by_len[k] = 1'b0;
      end
    end
  end

  assign used_len  = (cfg.pattern_length > lsf_pkg::PLEN_W'(NP)) ?
                     lsf_pkg::NSEL_W'(NP) : lsf_pkg::NSEL_W'(cfg.pattern_length);
  assign byte_room = (kept_length < lsf_pkg::LEN_W'(lsf_pkg::MAX_LINE_BYTES));
  assign kept_inc  = kept_length + 1'b1;
  assign hit       = (used_len != '0) &&
                     (kept_inc >= lsf_pkg::LEN_W'(used_len)) && hit_by_len[used_len];

  // line decision and counters
  assign matched    = ((cfg.pattern_length == '0) || found_in_line) ^ cfg.invert_select;
  assign line_inc   = line_counter + 32'd1;
  assign select_inc = select_counter + {31'd0, matched};

  // line state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NP; i++) window[i] <= '0;
      kept_length    <= '0;
      found_in_line  <= 1'b0;
      line_counter   <= '0;
      select_counter <= '0;
    end else if (pop) begin
      unique case (q_item.kind)
        lsf_pkg::KIND_BYTE: begin
          if (byte_room) begin
            for (int i = 0; i < NP; i++) window[i] <= window_next[i];
            kept_length <= kept_inc;
            if (hit) found_in_line <= 1'b1;
          end
        end
        lsf_pkg::KIND_NEWLINE: begin
          line_counter   <= line_inc;
          select_counter <= select_inc;
          kept_length    <= '0;
          found_in_line  <= 1'b0;
        end
        lsf_pkg::KIND_EOS: begin
          line_counter   <= '0;
          select_counter <= '0;
          kept_length    <= '0;
          found_in_line  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && produces) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop && produces) begin
      out_end <= (q_item.kind == lsf_pkg::KIND_EOS);
      if (q_item.kind == lsf_pkg::KIND_NEWLINE || kept_length != '0) begin
        out_line     <= 1'b1;
        out_selected <= matched;
        out_number   <= line_inc;
        out_length   <= kept_length;
        out_count    <= select_inc;
      end else begin
        out_line     <= 1'b0;
        out_selected <= 1'b0;
        out_number   <= '0;
        out_length   <= '0;
        out_count    <= select_counter;
      end
    end
  end

  assign m_tdata = {4'd0, out_count, out_length, out_number, out_selected};
  assign m_tuser = {out_line, out_end};

endmodule

// ===== rtl/line_substring_filter_core.sv =====
`timescale 1ns / 1ps

// line substring filter: reports, for each newline-terminated line of a byte
// stream, whether a fixed pattern of up to 16 bytes occurs in it
// input channel s_*: one request per byte; s_tuser is 0 for a text byte and
// 1 for end of stream, s_tdata carries the byte
// output channel m_*: one result per newline and per end of stream, none for
// other bytes; ordinary bytes and results stream at one request per cycle
// while m_tready takes each result; a request passes through the queue, then
// the window compare and result register in the back end, to m_tvalid
// the back end retires one request per cycle unless a result is blocked; the
// four-entry queue lets the input keep flowing while one result waits on
// m_tready, and only a full queue drops s_tready
// configuration is written through cfg_we / cfg_index / cfg_data while no
// request is in flight; indexes 0..4 are pattern length, pattern bytes 0-7,
// pattern bytes 8-15, ignore case, invert select
// synchronous reset clears the queue, window, counters, configuration and m_tvalid;
// the result payload is not reset; a stalled result holds its payload until taken
module line_substring_filter_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lsf_pkg::S_TDATA_W-1:0]     s_tdata,   // data_byte[7:0]
  input  logic                              s_tuser,   // opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // line_selected[0], line_number[32:1], line_length[43:33],
  // selected_count[75:44], zero fill[79:76]
  output logic [lsf_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic [lsf_pkg::M_TUSER_W-1:0]     m_tuser,   // is_stream_end[0], line_valid[1]
  input  logic                              cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;
  lsf_pkg::item_t  push_item;
  lsf_pkg::item_t  q_item;
  lsf_pkg::cfg_t   cfg;

  // request intake, classification and configuration
  lsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  // decoupling queue
  lsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_item    (q_item)
  );

  // window compare, line state and result register
  lsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== tb/sv/line_filter_checker.sv =====
`timescale 1ns / 1ps

module line_filter_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [lsf_pkg::S_TDATA_W-1:0]  s_tdata,   // data_byte[7:0]
  input  logic                           s_tuser,   // opcode
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // line_selected[0], line_number[32:1], line_length[43:33],
  // selected_count[75:44], zero fill[79:76]
  input  logic [lsf_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic [lsf_pkg::M_TUSER_W-1:0]  m_tuser,   // is_stream_end[0], line_valid[1]
  input  logic                           cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending,
  output int                             fail_count
);

  import lsf_pkg::*;

  typedef struct packed {
    logic        is_stream_end;
    logic        line_valid;
    logic        line_selected;
    logic [31:0] line_number;
    logic [10:0] line_length;
    logic [31:0] selected_count;
  } line_report_t;

  line_report_t line_reports[$];
  int           errors;

  // predicted block state
  logic [7:0]        recent [16];
  int                kept_len;
  logic              found;
  logic [31:0]       line_ctr;
  logic [31:0]       sel_ctr;

  // register copies, updated from the write port
  logic [PLEN_W-1:0] pat_len;
  logic [63:0]       pat_low;
  logic [63:0]       pat_high;
  logic              icase;
  logic              invert;

  function automatic logic [7:0] lower_if(input logic [7:0] c);
    if (icase && c >= UPPER_A && c <= UPPER_Z) return c + CASE_OFFSET;
    return c;
  endfunction

  function automatic logic [7:0] pattern_at(input int j);
    logic [127:0] all;
    all = {pat_high, pat_low};
    return all[j*8 +: 8];
  endfunction

  // shift a kept byte into the window and test the newest bytes
  function automatic void absorb_byte(input logic [7:0] c);
    int   n;
    int   i;
    logic hit;
    if (kept_len >= MAX_LINE_BYTES) return;
    for (i = 15; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = c;
    kept_len++;
    n = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len);
    if (n == 0 || kept_len < n) return;
    hit = 1'b1;
    for (i = 0; i < n; i++)
      if (lower_if(recent[n-1-i]) != lower_if(pattern_at(i))) hit = 1'b0;
    if (hit) found = 1'b1;
  endfunction

  function automatic line_report_t close_line(input logic at_end);
    line_report_t r;
    logic         sel;
    sel = ((pat_len == 0) || found) ^ invert;
    line_ctr++;
    if (sel) sel_ctr++;
    r.is_stream_end  = at_end;
    r.line_valid     = 1'b1;
    r.line_selected  = sel;
    r.line_number    = line_ctr;
    r.line_length    = kept_len[10:0];
    r.selected_count = sel_ctr;
    kept_len = 0;
    found    = 1'b0;
    return r;
  endfunction

  // end of stream: flush a trailing line, report the count, clear counters
  function automatic line_report_t end_stream();
    line_report_t r;
    if (kept_len > 0) begin
      r = close_line(1'b1);
    end else begin
      r.is_stream_end  = 1'b1;
      r.line_valid     = 1'b0;
      r.line_selected  = 1'b0;
      r.line_number    = '0;
      r.line_length    = '0;
      r.selected_count = sel_ctr;
    end
    line_ctr = '0;
    sel_ctr  = '0;
    kept_len = 0;
    found    = 1'b0;
    return r;
  endfunction

  function automatic string report_text(input line_report_t r);
    return $sformatf("end=%0d valid=%0d sel=%0d line=%0d len=%0d count=%0d",
                     r.is_stream_end, r.line_valid, r.line_selected,
                     r.line_number, r.line_length, r.selected_count);
  endfunction

  always @(posedge clk) begin
    line_report_t got;
    line_report_t want;
    int           i;
    if (rst) begin
      line_reports.delete();
      for (i = 0; i < 16; i++) recent[i] = '0;
      kept_len = 0;
      found    = 1'b0;
      line_ctr = '0;
      sel_ctr  = '0;
      pat_len  = '0;
      pat_low  = '0;
      pat_high = '0;
      icase    = 1'b0;
      invert   = 1'b0;
    end else begin
      // compare an accepted result with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.is_stream_end  = m_tuser[0];
        got.line_valid     = m_tuser[1];
        got.line_selected  = m_tdata[0];
        got.line_number    = m_tdata[32:1];
        got.line_length    = m_tdata[43:33];
        got.selected_count = m_tdata[75:44];
        if (line_reports.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected line report: %s", report_text(got));
        end else begin
          want = line_reports.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("line report mismatch: expected %s", report_text(want));
              $display("                      actual   %s", report_text(got));
            end
          end
        end
      end

      // predict from an accepted request
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_END) line_reports.push_back(end_stream());
        else if (s_tdata == NEWLINE_BYTE) line_reports.push_back(close_line(1'b0));
        else absorb_byte(s_tdata);
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: pat_len  = cfg_data[PLEN_W-1:0];
          REG_PATTERN_LOW:    pat_low  = cfg_data;
          REG_PATTERN_HIGH:   pat_high = cfg_data;
          REG_IGNORE_CASE:    icase    = cfg_data[0];
          REG_INVERT_SELECT:  invert   = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending    <= line_reports.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  import lsf_pkg::*;

  localparam int CYCLE_LIMIT     = 100000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_ITEMS    = 600;
  localparam int MIN_REPORTS     = 60;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    pending;
  int                    fail_count;

  int unsigned cycles = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;
  bit          hold_request = 1'b0;

  // stimulus-side view of the pattern, used to shape the text
  logic [7:0]  pat [16];
  int          pat_used = 0;
  bit          pat_icase = 1'b0;
  int          line_fill = 0;
  int          items_sent = 0;
  int          reports_sent = 0;

  line_substring_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_filter_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        m_tready <= sink_steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // one request on the input channel; entered and left at a falling edge
  task automatic send_item(input logic op, input logic [7:0] b);
    while (!src_steady && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op == OP_DATA && b != NEWLINE_BYTE) begin
      if (line_fill < MAX_LINE_BYTES) begin
        line_fill++;
        items_sent++;
      end
    end else begin
      line_fill = 0;
      items_sent++;
      reports_sent++;
    end
  endtask

  task automatic send_text(input string txt);
    int i;
    for (i = 0; i < txt.len(); i++) send_item(OP_DATA, txt[i]);
  endtask

  // wait until every result is in and the block has gone quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_pattern_length(input logic [PLEN_W-1:0] plen);
    write_reg(REG_PATTERN_LENGTH, 64'(plen));
    pat_used = (plen > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(plen);
  endtask

  task automatic apply_config(input logic [PLEN_W-1:0] plen, input logic [63:0] lo,
                              input logic [63:0] hi, input bit ic, input bit inv);
    int j;
    drain();
    set_pattern_length(plen);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_IGNORE_CASE, 64'(ic));
    write_reg(REG_INVERT_SELECT, 64'(inv));
    for (j = 0; j < 8; j++) begin
      pat[j]   = lo[j*8 +: 8];
      pat[j+8] = hi[j*8 +: 8];
    end
    pat_icase = ic;
  endtask

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return c ^ 8'h20;
    return c;
  endfunction

  // text drawn mostly from a small alphabet and the pattern itself
  function automatic logic [7:0] text_byte();
    int    r;
    string letters;
    letters = "aAbBx.";
    r = $urandom_range(99);
    if (r < 40 && pat_used > 0) begin
      if ($urandom_range(1)) return flip_case(pat[$urandom_range(pat_used - 1)]);
      return pat[$urandom_range(pat_used - 1)];
    end
    if (r < 85) return letters[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  // one copy of the pattern, case flipped under ignore case, sometimes spoiled
  task automatic send_pattern_copy();
    int         j;
    int         spoil;
    logic [7:0] b;
    spoil = ($urandom_range(99) < 20) ? $urandom_range(pat_used - 1) : -1;
    for (j = 0; j < pat_used; j++) begin
      b = pat[j];
      if (pat_icase && $urandom_range(1)) b = flip_case(b);
      if (j == spoil) b = b ^ 8'h01;
      send_item(OP_DATA, b);
    end
  endtask

  task automatic send_line(input bit terminate);
    int n;
    int at;
    int i;
    n  = ($urandom_range(99) < 80) ? $urandom_range(0, 10) : $urandom_range(11, 40);
    at = (pat_used > 0 && $urandom_range(99) < 50) ? $urandom_range(0, n) : -1;
    for (i = 0; i <= n; i++) begin
      if (i == at) send_pattern_copy();
      if (i < n) send_item(OP_DATA, text_byte());
    end
    if (terminate) send_item(OP_DATA, NEWLINE_BYTE);
  endtask

  // line past the kept limit, pattern placed at a chosen offset
  task automatic send_long_line(input int n, input int at);
    int keep;
    int i;
    keep = items_sent;
    for (i = 0; i < n; i++) begin
      if (i == at && pat_used > 0) send_pattern_copy();
      send_item(OP_DATA, ".");
    end
    send_item(OP_DATA, NEWLINE_BYTE);
    items_sent = keep;
  endtask

  task automatic run_phase(input int k);
    logic [PLEN_W-1:0] plen;
    logic [63:0]       lo;
    logic [63:0]       hi;
    int                r;
    int                j;
    int                lines;
    string             pat_chars;
    pat_chars = "aAbBxyz";
    lo = '0;
    hi = '0;
    for (j = 0; j < 8; j++) begin
      lo[j*8 +: 8] = ($urandom_range(99) < 70) ? pat_chars[$urandom_range(6)]
                                               : 8'($urandom_range(255));
      hi[j*8 +: 8] = ($urandom_range(99) < 70) ? pat_chars[$urandom_range(6)]
                                               : 8'($urandom_range(255));
    end
    r = $urandom_range(99);
    case (k)
      0: plen = 5'd16;
      1: plen = 5'd1;
      2: plen = 5'd0;
      3: plen = 5'd31;
      5: begin
        plen = 5'd9;
        lo   = '1;
        hi   = '1;
      end
      default: begin
        if (r < 10) plen = 5'd0;
        else if (r < 20) plen = 5'($urandom_range(17, 31));
        else if (r < 30) plen = 5'd16;
        else plen = 5'($urandom_range(1, 8));
      end
    endcase
    apply_config(plen, lo, hi, $urandom_range(1), $urandom_range(1));

    // steady stretch with no idling on either side
    src_steady  = (k == 4);
    sink_steady = (k == 4);

    // bytes at and past the line limit
    if (k == 1) begin
      send_long_line(1030, MAX_LINE_BYTES - pat_used);
      send_long_line(1100, MAX_LINE_BYTES + 1);
    end

    // long receiver hold-off while short lines keep coming
    if (k == 3) begin
      drain();
      hold_request = 1'b1;
      for (j = 0; j < 40; j++) begin
        send_item(OP_DATA, text_byte());
        send_item(OP_DATA, NEWLINE_BYTE);
      end
      drain();
    end

    lines = $urandom_range(5, 15);
    for (j = 0; j < lines; j++) begin
      if ($urandom_range(99) < 10) begin
        // register change in the middle of a line
        send_line(1'b0);
        drain();
        case ($urandom_range(2))
          0: write_reg(REG_INVERT_SELECT, 64'($urandom_range(1)));
          1: begin
            pat_icase = $urandom_range(1);
            write_reg(REG_IGNORE_CASE, 64'(pat_icase));
          end
          default: set_pattern_length(5'($urandom_range(0, 16)));
        endcase
        send_line(1'b1);
      end else begin
        send_line(1'b1);
      end
    end

    // sometimes close the stream, sometimes with a trailing unterminated line
    r = $urandom_range(99);
    if (r < 30) begin
      send_line(1'b0);
      send_item(OP_END, 8'($urandom_range(255)));
    end else if (r < 60) begin
      send_item(OP_END, 8'($urandom_range(255)));
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    int k;
    int base_items;
    int base_reports;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OP_DATA;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (k = 0; k < 16; k++) pat[k] = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pattern after reset matches everything
    send_item(OP_END, 8'h00);
    send_text("\n");
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_text("\n");
    send_text("q");
    send_item(OP_END, 8'hFF);

    // case folding, and a pattern longer than the kept line
    apply_config(5'd2, 64'h6241, 64'h0, 1'b1, 1'b0);
    send_text("xaB\n");
    send_text("A\n");

    // inversion switched on after the hit but before the newline
    send_text("ab");
    drain();
    write_reg(REG_INVERT_SELECT, 64'd1);
    send_text("\n");
    send_text("zz\n");

    // oversized length, all-ones pattern bytes
    apply_config(5'd31, '1, '1, 1'b0, 1'b0);
    send_text("\n");
    send_item(OP_END, 8'h00);

    // random phases until enough text and results have gone through
    base_items   = items_sent;
    base_reports = reports_sent;
    k = 0;
    while (items_sent - base_items < RANDOM_ITEMS ||
           reports_sent - base_reports < MIN_REPORTS) begin
      run_phase(k);
      k++;
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
